// ----- hw/rtl/bsp_pkg.sv -----
package bsp_pkg;

    // Input item kinds carried in the slave-side tuser.
    localparam logic [1:0] OP_LOAD_PT  = 2'd0;
    localparam logic [1:0] OP_LOAD_ARC = 2'd1;
    localparam logic [1:0] OP_EVAL_PT  = 2'd2;
    localparam logic [1:0] OP_EVAL_DER = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_CFG = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SEGS = 2'd0;
    localparam logic [1:0] CFG_DIMS = 2'd1;
    localparam logic [1:0] CFG_TPTS = 2'd2;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_ARC_RD,
        S_ARC_CMP,
        S_ARC_LO,
        S_ARC_LOQ,
        S_ARC_M1,
        S_ARC_M2,
        S_ARC_DIV,
        S_ARC_WAIT,
        S_CHECK,
        S_SEG,
        S_SEG2,
        S_WGT,
        S_AXIS,
        S_OUT
    } t_state;

endpackage

// ----- hw/rtl/bezier_spline_point_eval.sv -----
// Piecewise cubic Bezier evaluator built around one shared 35x35 multiplier.
// Load items: result valid in the cycle after the input beat is taken.
// Evaluate items: check, segment split, weights, then one pass per axis (2 or
// 3 axes), or straight to the result on a nonzero status; arc-length mode first
// searches the table, sets up and runs the divider. One item at a time; the
// input is ready only while the sequencer is idle. Synchronous active-low reset
// sets segments, dimensions and table size to 2.
module bezier_spline_point_eval
    import bsp_pkg::*;
#(
    parameter int MAX_SEGMENTS = 16,
    parameter int TABLE_DEPTH  = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // slot[5:0], coord_x[37:6], coord_y[69:38], coord_z[101:70], param[118:102]
    input  logic [119:0] i_s_tdata,
    // opcode[1:0], arc_mode[2]
    input  logic [2:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // res_x[31:0], res_y[63:32], res_z[95:64]
    output logic [95:0]  o_m_tdata,
    // status[1:0]
    output logic [1:0]   o_m_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [6:0]   i_cfg_data
);

    localparam int CTRL_DEPTH = 3 * MAX_SEGMENTS + 1;
    localparam int CAW = $clog2(CTRL_DEPTH);
    localparam int TAW = $clog2(TABLE_DEPTH);
    localparam int NNW = $clog2(TABLE_DEPTH + 1);
    localparam int TW  = 46;
    localparam int NUM_W = 45;
    localparam int DEN_W = 28;
    localparam int ACW = 68;

    t_state r_state, n_state;

    // Configuration registers.
    logic [4:0] r_segs;
    logic [1:0] r_dims;
    logic [6:0] r_tpts;

    // Item registers.
    logic [1:0]           r_op;
    logic signed [TW-1:0] r_t;
    logic [TAW-1:0]       r_i;
    logic [16:0]          r_hi, r_lo;
    logic signed [TW-1:0] r_num;
    logic                 r_neg;
    logic [16:0]          r_u, r_v;
    logic [CAW-1:0]       r_base;
    logic [2:0]           r_k;
    logic [1:0]           r_axis;
    logic [32:0]          r_vv, r_uu;
    logic [30:0]          r_w [4];
    logic signed [31:0]   r_pp;
    logic signed [ACW-1:0] r_acc;
    logic signed [69:0]   r_prod;
    logic [1:0]           r_status;
    logic [31:0]          r_res [3];

    // Input beat fields.
    logic [1:0]  in_op;
    logic        in_arc;
    logic [5:0]  in_slot;
    logic [31:0] in_x, in_y, in_z;
    logic [16:0] in_param;
    logic        s_acc;

    assign in_op    = i_s_tuser[1:0];
    assign in_arc   = i_s_tuser[2];
    assign in_slot  = i_s_tdata[5:0];
    assign in_x     = i_s_tdata[37:6];
    assign in_y     = i_s_tdata[69:38];
    assign in_z     = i_s_tdata[101:70];
    assign in_param = i_s_tdata[118:102];
    assign s_acc    = i_s_tvalid && o_s_tready;

    // Configuration port, always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_segs <= 5'd2;
            r_dims <= 2'd2;
            r_tpts <= 7'd2;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SEGS: r_segs <= i_cfg_data[4:0];
                CFG_DIMS: r_dims <= i_cfg_data[1:0];
                CFG_TPTS: r_tpts <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // Storage for control points and the arc table.
    logic           ctrl_we, arc_we;
    logic [CAW-1:0] ctrl_raddr;
    logic [TAW-1:0] arc_raddr;
    logic [31:0]    q_x, q_y, q_z;
    logic [16:0]    q_arc;

    assign ctrl_we = s_acc && (in_op == OP_LOAD_PT) && (32'(in_slot) < 32'(CTRL_DEPTH));
    assign arc_we  = s_acc && (in_op == OP_LOAD_ARC) && (32'(in_slot) < 32'(TABLE_DEPTH));

    bsp_ram #(.WIDTH(32), .DEPTH(CTRL_DEPTH)) u_ram_x (
        .i_clk(i_clk), .i_we(ctrl_we), .i_waddr(CAW'(in_slot)), .i_wdata(in_x),
        .i_raddr(ctrl_raddr), .o_rdata(q_x)
    );
    bsp_ram #(.WIDTH(32), .DEPTH(CTRL_DEPTH)) u_ram_y (
        .i_clk(i_clk), .i_we(ctrl_we), .i_waddr(CAW'(in_slot)), .i_wdata(in_y),
        .i_raddr(ctrl_raddr), .o_rdata(q_y)
    );
    bsp_ram #(.WIDTH(32), .DEPTH(CTRL_DEPTH)) u_ram_z (
        .i_clk(i_clk), .i_we(ctrl_we), .i_waddr(CAW'(in_slot)), .i_wdata(in_z),
        .i_raddr(ctrl_raddr), .o_rdata(q_z)
    );
    bsp_ram #(.WIDTH(17), .DEPTH(TABLE_DEPTH)) u_ram_arc (
        .i_clk(i_clk), .i_we(arc_we), .i_waddr(TAW'(in_slot)), .i_wdata(in_param),
        .i_raddr(arc_raddr), .o_rdata(q_arc)
    );

    // Derived values used by several states.
    logic [NNW-1:0]     tbl_n;
    logic               srch_more;
    logic signed [17:0] arc_d;
    logic               deriv;
    logic               cfg_bad;
    logic               t_bad;
    logic [1:0]         last_axis;

    always_comb begin
        if (r_tpts < 7'd2) begin
            tbl_n = NNW'(2);
        end else if (32'(r_tpts) > 32'(TABLE_DEPTH)) begin
            tbl_n = NNW'(TABLE_DEPTH);
        end else begin
            tbl_n = NNW'(r_tpts);
        end
    end

    assign srch_more = (32'(r_i) + 32'd1 < 32'(tbl_n)) && (q_arc < r_t[16:0]);
    assign arc_d     = signed'({1'b0, r_hi}) - signed'({1'b0, r_lo});
    assign deriv     = (r_op == OP_EVAL_DER);
    assign cfg_bad   = (r_segs < 5'd2) || (32'(r_segs) > 32'(MAX_SEGMENTS)) ||
                       ((r_dims != 2'd2) && (r_dims != 2'd3));
    assign t_bad     = r_t[TW-1] || (r_t > TW'(signed'(65537)) - TW'(1));
    assign last_axis = (r_dims == 2'd3) ? 2'd2 : 2'd1;

    // Segment split from the registered product t*m.
    logic [21:0] seg_p;
    logic [5:0]  seg_raw, seg_sel;
    logic [16:0] seg_u;
    logic [7:0]  seg_base;

    always_comb begin
        seg_p   = r_prod[21:0];
        seg_raw = seg_p[21:16];
        seg_sel = (seg_raw >= {1'b0, r_segs}) ? 6'({1'b0, r_segs} - 6'd1) : seg_raw;
        seg_u   = 17'(seg_p - {seg_sel, 16'd0});
        seg_base = {1'b0, seg_sel, 1'b0} + {2'b0, seg_sel};
    end

    // Divider for the arc-length interpolation.
    logic             div_start;
    logic             div_done;
    logic [NUM_W-1:0] div_quot;
    logic             div_rnz;
    logic [NUM_W-1:0] num_mag;
    logic [DEN_W-1:0] den_mag;
    logic signed [TW-1:0] neg_num;
    logic signed [69:0]   neg_prod;

    assign neg_num  = -r_num;
    assign neg_prod = -r_prod;
    assign num_mag  = r_num[TW-1] ? neg_num[NUM_W-1:0] : r_num[NUM_W-1:0];
    assign den_mag  = (arc_d == 18'sd0) ? DEN_W'(tbl_n - NNW'(1)) :
                      (r_prod[69] ? neg_prod[DEN_W-1:0] : r_prod[DEN_W-1:0]);

    bsp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(num_mag), .i_den(den_mag),
        .o_done(div_done), .o_quot(div_quot), .o_rem_nz(div_rnz)
    );

    // Point of the current axis read back from storage.
    logic signed [31:0] axis_q;
    logic signed [32:0] axis_diff;

    always_comb begin
        case (r_axis)
            2'd0:    axis_q = signed'(q_x);
            2'd1:    axis_q = signed'(q_y);
            default: axis_q = signed'(q_z);
        endcase
        axis_diff = 33'(axis_q) - 33'(r_pp);
    end

    // Rounding of the accumulated axis sum to Q16.16 with saturation.
    logic signed [69:0] fin_x, fin_sh;
    logic [31:0]        fin_val;

    always_comb begin
        if (deriv) begin
            fin_x  = (70'(r_acc) <<< 1) + 70'(r_acc);
            fin_sh = (fin_x + (70'sd1 <<< 27)) >>> 28;
        end else begin
            fin_x  = 70'(r_acc);
            fin_sh = (fin_x + (70'sd1 <<< 29)) >>> 30;
        end
        if (fin_sh > 70'sd2147483647) begin
            fin_val = 32'h7FFF_FFFF;
        end else if (fin_sh < -70'sd2147483648) begin
            fin_val = 32'h8000_0000;
        end else begin
            fin_val = fin_sh[31:0];
        end
    end

    function automatic logic [30:0] rnd18(input logic signed [69:0] x);
        logic signed [69:0] s;
        s = (x + 70'sd131072) >>> 18;
        return s[30:0];
    endfunction

    logic signed [69:0] prod3;
    assign prod3 = (r_prod <<< 1) + r_prod;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    if ((in_op == OP_LOAD_PT) || (in_op == OP_LOAD_ARC)) begin
                        n_state = S_OUT;
                    end else if (in_arc) begin
                        n_state = S_ARC_RD;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_ARC_RD:   n_state = S_ARC_CMP;
            S_ARC_CMP:  n_state = srch_more ? S_ARC_RD : S_ARC_LO;
            S_ARC_LO:   n_state = S_ARC_LOQ;
            S_ARC_LOQ:  n_state = S_ARC_M1;
            S_ARC_M1:   n_state = S_ARC_M2;
            S_ARC_M2:   n_state = S_ARC_DIV;
            S_ARC_DIV:  n_state = S_ARC_WAIT;
            S_ARC_WAIT: n_state = div_done ? S_CHECK : S_ARC_WAIT;
            S_CHECK:    n_state = (cfg_bad || t_bad) ? S_OUT : S_SEG;
            S_SEG:      n_state = S_SEG2;
            S_SEG2:     n_state = S_WGT;
            S_WGT:      n_state = (r_k == 3'd7) ? S_AXIS : S_WGT;
            S_AXIS: begin
                if ((r_k == 3'd6) && (r_axis == last_axis)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT:      n_state = i_m_tready ? S_IDLE : S_OUT;
            default:    n_state = S_IDLE;
        endcase
    end

    // Outputs, memory addresses and multiplier operands.
    logic signed [34:0] mul_a, mul_b;

    always_comb begin
        o_s_tready = (r_state == S_IDLE);
        o_m_tvalid = (r_state == S_OUT);
        div_start  = (r_state == S_ARC_DIV);
        arc_raddr  = (r_state == S_ARC_LO) ? r_i - TAW'(1) : r_i;
        ctrl_raddr = r_base + CAW'(r_k);
        mul_a      = '0;
        mul_b      = '0;
        case (r_state)
            S_ARC_M1: begin
                mul_a = signed'(35'(r_i));
                mul_b = 35'(arc_d);
            end
            S_ARC_M2: begin
                mul_a = 35'(arc_d);
                mul_b = signed'(35'(tbl_n - NNW'(1)));
            end
            S_SEG: begin
                mul_a = signed'(35'(r_t[16:0]));
                mul_b = signed'(35'(r_segs));
            end
            S_WGT: begin
                case (r_k)
                    3'd0: begin mul_a = signed'(35'(r_v)); mul_b = signed'(35'(r_v)); end
                    3'd1: begin
                        mul_a = signed'(35'(r_prod[32:0]));
                        mul_b = signed'(35'(r_v));
                    end
                    3'd2: begin mul_a = signed'(35'(r_vv)); mul_b = signed'(35'(r_u)); end
                    3'd3: begin mul_a = signed'(35'(r_u)); mul_b = signed'(35'(r_u)); end
                    3'd4: begin
                        mul_a = signed'(35'(r_prod[32:0]));
                        mul_b = signed'(35'(r_v));
                    end
                    3'd5: begin mul_a = signed'(35'(r_uu)); mul_b = signed'(35'(r_u)); end
                    3'd6: begin mul_a = signed'(35'(r_u)); mul_b = signed'(35'(r_v)); end
                    default: ;
                endcase
            end
            S_AXIS: begin
                if ((r_k >= 3'd1) && (r_k <= 3'd4)) begin
                    if (deriv) begin
                        if (r_k >= 3'd2) begin
                            mul_a = signed'(35'(r_w[2'(r_k - 3'd2)]));
                            mul_b = 35'(axis_diff);
                        end
                    end else begin
                        mul_a = signed'(35'(r_w[2'(r_k - 3'd1)]));
                        mul_b = 35'(axis_q);
                    end
                end
            end
            default: ;
        endcase
    end

    // Shared multiplier, registered.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_axis  <= '0;
            r_i     <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE:    r_i <= TAW'(1);
                S_ARC_CMP: if (srch_more) r_i <= r_i + TAW'(1);
                S_SEG2:    r_k <= '0;
                S_WGT: begin
                    r_k <= (r_k == 3'd7) ? 3'd0 : r_k + 3'd1;
                    r_axis <= '0;
                end
                S_AXIS: begin
                    if (r_k == 3'd6) begin
                        r_k    <= '0;
                        r_axis <= r_axis + 2'd1;
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    r_op     <= in_op;
                    r_t      <= TW'(in_param);
                    r_status <= ST_OK;
                    r_res[0] <= '0;
                    r_res[1] <= '0;
                    r_res[2] <= '0;
                end
            end
            S_ARC_CMP: if (!srch_more) r_hi <= q_arc;
            S_ARC_LOQ: r_lo <= q_arc;
            S_ARC_M2: begin
                if (arc_d == 18'sd0) begin
                    r_num <= TW'(r_i) <<< 16;
                end else begin
                    r_num <= (TW'(r_prod) - TW'(r_hi) + r_t) <<< 16;
                end
            end
            S_ARC_DIV: r_neg <= r_num[TW-1] ^ (arc_d < 18'sd0);
            S_ARC_WAIT: begin
                if (div_done) begin
                    r_t <= r_neg ? -(TW'(div_quot) + TW'(div_rnz)) : TW'(div_quot);
                end
            end
            S_CHECK: begin
                if (cfg_bad) begin
                    r_status <= ST_BAD_CFG;
                end else if (t_bad) begin
                    r_status <= ST_RANGE;
                end
            end
            S_SEG2: begin
                r_u    <= seg_u;
                r_v    <= 17'd65536 - seg_u;
                r_base <= CAW'(seg_base);
            end
            S_WGT: begin
                case (r_k)
                    3'd1: r_vv <= r_prod[32:0];
                    3'd2: r_w[0] <= rnd18(r_prod);
                    3'd3: r_w[1] <= rnd18(prod3);
                    3'd4: r_uu <= r_prod[32:0];
                    3'd5: r_w[2] <= rnd18(prod3);
                    3'd6: r_w[3] <= rnd18(r_prod);
                    3'd7: begin
                        if (deriv) begin
                            r_w[0] <= 31'((34'(r_vv) + 34'd8) >> 4);
                            r_w[1] <= 31'(((34'(r_prod[31:0]) << 1) + 34'd8) >> 4);
                            r_w[2] <= 31'((34'(r_uu) + 34'd8) >> 4);
                        end
                    end
                    default: ;
                endcase
            end
            S_AXIS: begin
                if (r_k == 3'd0) begin
                    r_acc <= '0;
                end else if ((r_k >= 3'd2) && (r_k <= 3'd5) && (!deriv || r_k >= 3'd3)) begin
                    r_acc <= r_acc + ACW'(r_prod);
                end
                if ((r_k >= 3'd1) && (r_k <= 3'd4)) begin
                    r_pp <= axis_q;
                end
                if (r_k == 3'd6) begin
                    r_res[r_axis] <= fin_val;
                end
            end
            default: ;
        endcase
    end

    assign o_m_tdata = {r_res[2], r_res[1], r_res[0]};
    assign o_m_tuser = r_status;

endmodule

// ----- hw/rtl/bsp_ram.sv -----
module bsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/bsp_div.sv -----
module bsp_div #(
    parameter int NUM_W = 45,
    parameter int DEN_W = 28,
    localparam int CW = $clog2(NUM_W + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot,
    output logic             o_rem_nz
);

    logic [CW-1:0]    r_cnt;
    logic             r_done;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   trial;
    logic             ge;

    // Restoring division, one quotient bit per cycle.
    assign shifted = {r_rem, r_quo[NUM_W-1]};
    assign trial   = shifted - {1'b0, r_den};
    assign ge      = (shifted >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(NUM_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], ge};
        end
    end

    assign o_done   = r_done;
    assign o_quot   = r_quo;
    assign o_rem_nz = |r_rem;

endmodule
